// ===== design/item_location_box_parse_and_lookup_macros.svh =====
// Assertion macros shared by the item location checker
`ifndef ITEM_LOCATION_BOX_PARSE_AND_LOOKUP_MACROS_SVH
`define ITEM_LOCATION_BOX_PARSE_AND_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ILBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("item location check failed");

// Next-cycle implication, sampled on clk, off during reset
`define ILBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("item location check failed");

`endif

// ===== design/ilbl_pkg.sv =====
// Types and constants of the item location box parser
package ilbl_pkg;

  typedef enum logic [3:0] {
    PH_SIZE_A, PH_SIZE_B, PH_COUNT, PH_ITEM, PH_METHOD, PH_DREF,
    PH_BASE, PH_EXTCNT, PH_INDEX, PH_OFFSET, PH_LENGTH, PH_DONE
  } parse_phase_t;

  typedef enum logic [2:0] {
    LK_IDLE, LK_SCAN, LK_SUM, LK_ADD, LK_FIN
  } lookup_state_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_PARSE_ERR   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ST_EXTENT_CNT  = 3'd3;
  localparam logic [2:0] ST_IDAT_OVFL   = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

  localparam logic ACTION_BYTE   = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;
  localparam logic KIND_PARSE    = 1'b0;
  localparam logic KIND_LOOKUP   = 1'b1;

  localparam logic [7:0] VERSION_MAX = 8'd2;
  localparam logic [3:0] METHOD_FILE = 4'd0;
  localparam logic [3:0] METHOD_IDAT = 4'd1;

  typedef struct packed {
    logic [31:0] item_id;
    logic [3:0]  method;
    logic [63:0] base;
    logic        has_ext;
    logic [63:0] ext_off;
    logic [63:0] ext_len;
  } entry_t;

  function automatic logic size_ok(input logic [3:0] s);
    return (s == 4'd0) || (s == 4'd4) || (s == 4'd8);
  endfunction

endpackage

// ===== design/item_location_box_parse_and_lookup.sv =====
// Item location box parser with entry table and item location lookup
//
//   channel | ports                         | role
//   --------+-------------------------------+------------------------------------
//   in      | in_valid/in_ready + fields    | payload bytes and lookup requests
//   out     | out_valid/out_ready + fields  | parse status at box end, lookups
//   cfg     | cfg_wr_en/cfg_wr_data         | box version, written at once
//
// Each payload byte is decoded as it is accepted; the entry table row is written on entry end.
// A lookup scans the table one entry a cycle through its single read port;
// no bytes are accepted meanwhile.
// rst_n is synchronous; it empties the table by clearing the entry index.
// A byte that ends no box is taken even while a result waits on out.
module item_location_box_parse_and_lookup import ilbl_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_box_byte,
  input  logic        in_box_last,
  input  logic [31:0] in_item_id,
  input  logic [63:0] in_idat_offset,
  input  logic [31:0] in_idat_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [2:0]  out_status,
  output logic [63:0] out_item_offset,
  output logic [31:0] out_item_length,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  // parse state
  parse_phase_t phase_r, phase_nxt, ph;
  logic [3:0]   fcnt_r, fcnt_nxt, fcnt_inc, fw;
  logic [63:0]  acc_r, acc_nxt, v;
  logic [3:0]   off_sz_r, off_sz_nxt, len_sz_r, len_sz_nxt;
  logic [3:0]   base_sz_r, base_sz_nxt, idx_sz_r, idx_sz_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, eidx_r, eidx_nxt, eidx_inc;
  logic         err_r, err_nxt;
  entry_t       cur_r, cur_nxt;
  logic         has_meth, entry_end, wr_en, bad;
  logic [7:0]   version_r;

  // lookup state
  lookup_state_t lk_state_r, lk_state_nxt;
  logic [CW-1:0] scan_r;
  logic          rvld_r, nf_r, issue, match, scan_end;
  logic [31:0]   id_r, idat_sz_r;
  logic [63:0]   idat_off_r;
  entry_t        hit_r, rd_q;
  logic [63:0]   s1_r, s2_r, offs_r;
  logic          c1_r, c2_r;
  logic [2:0]    fin_status;
  logic [63:0]   fin_off;
  logic [31:0]   fin_len;

  logic byte_acc, lk_acc, fin_go;

  // output register
  logic        out_valid_r, out_kind_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_off_r;
  logic [31:0] out_len_r;

  entry_t mem [MAX_ITEMS];

  assign byte_acc = in_valid && in_ready && (in_action == ACTION_BYTE);
  assign lk_acc   = in_valid && in_ready && (in_action == ACTION_LOOKUP);
  assign has_meth = (version_r == 8'd1) || (version_r == 8'd2);

  // decode one payload byte
  always_comb begin
    phase_nxt   = phase_r;
    fcnt_nxt    = fcnt_r;
    acc_nxt     = acc_r;
    off_sz_nxt  = off_sz_r;
    len_sz_nxt  = len_sz_r;
    base_sz_nxt = base_sz_r;
    idx_sz_nxt  = idx_sz_r;
    cnt_nxt     = cnt_r;
    eidx_nxt    = eidx_r;
    err_nxt     = err_r;
    cur_nxt     = cur_r;
    entry_end   = 1'b0;
    wr_en       = 1'b0;
    bad         = 1'b0;
    ph          = phase_r;
    v           = {acc_r[55:0], in_box_byte};
    fcnt_inc    = fcnt_r + 4'd1;
    eidx_inc    = eidx_r + CW'(1);
    if (ph == PH_SIZE_A) begin
      cnt_nxt  = '0;
      eidx_nxt = '0;
      err_nxt  = 1'b0;
      if (version_r > VERSION_MAX) begin
        err_nxt = 1'b1;
        ph      = PH_DONE;
      end
    end
    case (ph)
      PH_COUNT, PH_ITEM: fw = (version_r < 8'd2) ? 4'd2 : 4'd4;
      PH_METHOD:         fw = has_meth ? 4'd2 : 4'd0;
      PH_DREF, PH_EXTCNT: fw = 4'd2;
      PH_BASE:           fw = base_sz_r;
      PH_INDEX:          fw = idx_sz_r;
      PH_OFFSET:         fw = off_sz_r;
      PH_LENGTH:         fw = len_sz_r;
      default:           fw = 4'd1;
    endcase
    if (ph != PH_DONE) begin
      if (fcnt_inc >= fw) begin
        acc_nxt  = '0;
        fcnt_nxt = '0;
        case (ph)
          PH_SIZE_A: begin
            off_sz_nxt = v[7:4];
            len_sz_nxt = v[3:0];
            ph = PH_SIZE_B;
          end
          PH_SIZE_B: begin
            base_sz_nxt = v[7:4];
            idx_sz_nxt  = has_meth ? v[3:0] : 4'd0;
            if (!size_ok(off_sz_r) || !size_ok(len_sz_r) || !size_ok(v[7:4]) ||
                !size_ok(idx_sz_nxt)) begin
              err_nxt = 1'b1;
              ph = PH_DONE;
            end else begin
              ph = PH_COUNT;
            end
          end
          PH_COUNT: begin
            cnt_nxt = v[CW-1:0];
            if (v[31:0] > 32'(MAX_ITEMS)) begin
              err_nxt = 1'b1;
              ph = PH_DONE;
            end else if (v[31:0] == 32'd0) begin
              ph = PH_DONE;
            end else begin
              ph = PH_ITEM;
            end
          end
          PH_ITEM: begin
            if (32'(eidx_r) >= 32'(MAX_ITEMS)) begin
              err_nxt = 1'b1;
              ph = PH_DONE;
            end else begin
              cur_nxt = '0;
              cur_nxt.item_id = v[31:0];
              ph = has_meth ? PH_METHOD : PH_DREF;
            end
          end
          PH_METHOD: begin
            cur_nxt.method = v[3:0];
            ph = PH_DREF;
          end
          PH_DREF: begin
            if (v != 64'd0) begin
              err_nxt = 1'b1;
              ph = PH_DONE;
            end else begin
              ph = PH_BASE;
            end
          end
          PH_BASE: begin
            cur_nxt.base = v;
            ph = PH_EXTCNT;
          end
          PH_EXTCNT: begin
            if (v > 64'd1) begin
              err_nxt = 1'b1;
              ph = PH_DONE;
            end else if (v == 64'd1) begin
              cur_nxt.has_ext = 1'b1;
              ph = PH_INDEX;
            end else begin
              entry_end = 1'b1;
            end
          end
          PH_INDEX: ph = PH_OFFSET;
          PH_OFFSET: begin
            cur_nxt.ext_off = v;
            ph = PH_LENGTH;
          end
          PH_LENGTH: begin
            cur_nxt.ext_len = v;
            entry_end = 1'b1;
          end
          default: ph = PH_DONE;
        endcase
        // skip fields of zero size; their values stay zero
        if (!entry_end) begin
          if ((ph == PH_BASE) && (base_sz_r == 4'd0)) ph = PH_EXTCNT;
          if ((ph == PH_INDEX) && (idx_sz_r == 4'd0)) ph = PH_OFFSET;
          if ((ph == PH_OFFSET) && (off_sz_r == 4'd0)) ph = PH_LENGTH;
          if ((ph == PH_LENGTH) && (len_sz_r == 4'd0)) entry_end = 1'b1;
        end
        if (entry_end) begin
          wr_en    = 1'b1;
          eidx_nxt = eidx_inc;
          ph = (eidx_inc >= cnt_r) ? PH_DONE : PH_ITEM;
        end
      end else begin
        acc_nxt  = v;
        fcnt_nxt = fcnt_inc;
      end
    end
    phase_nxt = ph;
    // close the box on its last byte
    if (in_box_last) begin
      bad = err_nxt || (ph != PH_DONE);
      if (bad) begin
        cnt_nxt  = '0;
        eidx_nxt = '0;
      end
      err_nxt   = 1'b0;
      phase_nxt = PH_SIZE_A;
      fcnt_nxt  = '0;
      acc_nxt   = '0;
    end
  end

  // parse control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIZE_A;
      fcnt_r    <= '0;
      acc_r     <= '0;
      off_sz_r  <= '0;
      len_sz_r  <= '0;
      base_sz_r <= '0;
      idx_sz_r  <= '0;
      cnt_r     <= '0;
      eidx_r    <= '0;
      err_r     <= 1'b0;
      version_r <= '0;
    end else begin
      if (cfg_wr_en) version_r <= cfg_wr_data;
      if (byte_acc) begin
        phase_r   <= phase_nxt;
        fcnt_r    <= fcnt_nxt;
        acc_r     <= acc_nxt;
        off_sz_r  <= off_sz_nxt;
        len_sz_r  <= len_sz_nxt;
        base_sz_r <= base_sz_nxt;
        idx_sz_r  <= idx_sz_nxt;
        cnt_r     <= cnt_nxt;
        eidx_r    <= eidx_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  // entry under construction
  always_ff @(posedge clk) begin
    if (byte_acc) cur_r <= cur_nxt;
  end

  // entry table: write on entry end, read during scan
  always_ff @(posedge clk) begin
    if (byte_acc && wr_en) mem[eidx_r[AW-1:0]] <= cur_nxt;
    if (issue) rd_q <= mem[scan_r[AW-1:0]];
  end

  assign match    = rvld_r && (rd_q.item_id == id_r);
  assign scan_end = !rvld_r && (scan_r == eidx_r);

  // lookup next state
  always_comb begin
    lk_state_nxt = lk_state_r;
    case (lk_state_r)
      LK_IDLE: if (lk_acc) lk_state_nxt = LK_SCAN;
      LK_SCAN: begin
        if (match) lk_state_nxt = LK_SUM;
        else if (scan_end) lk_state_nxt = LK_FIN;
      end
      LK_SUM:  lk_state_nxt = LK_ADD;
      LK_ADD:  lk_state_nxt = LK_FIN;
      LK_FIN:  if (!out_valid_r || out_ready) lk_state_nxt = LK_IDLE;
      default: lk_state_nxt = LK_IDLE;
    endcase
  end

  // lookup outputs
  always_comb begin
    in_ready = (lk_state_r == LK_IDLE) &&
               (!out_valid_r || out_ready ||
                ((in_action == ACTION_BYTE) && !in_box_last));
    issue    = (lk_state_r == LK_SCAN) && (scan_r < eidx_r) && !match;
    fin_go   = (lk_state_r == LK_FIN) && (!out_valid_r || out_ready);
  end

  // lookup control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_state_r <= LK_IDLE;
      scan_r     <= '0;
      rvld_r     <= 1'b0;
      nf_r       <= 1'b0;
    end else begin
      lk_state_r <= lk_state_nxt;
      if (lk_acc) begin
        scan_r <= '0;
        rvld_r <= 1'b0;
        nf_r   <= 1'b0;
      end else if (lk_state_r == LK_SCAN) begin
        if (issue) scan_r <= scan_r + CW'(1);
        rvld_r <= issue;
        if (!match && scan_end) nf_r <= 1'b1;
      end
    end
  end

  // lookup datapath: capture request, hit row, then two adder stages
  always_ff @(posedge clk) begin
    if (lk_acc) begin
      id_r       <= in_item_id;
      idat_off_r <= in_idat_offset;
      idat_sz_r  <= in_idat_size;
    end
    if ((lk_state_r == LK_SCAN) && match) hit_r <= rd_q;
    if (lk_state_r == LK_SUM) {c1_r, s1_r} <= {1'b0, hit_r.base} + {1'b0, hit_r.ext_off};
    if (lk_state_r == LK_ADD) begin
      {c2_r, s2_r} <= {1'b0, s1_r} + {1'b0, hit_r.ext_len};
      offs_r       <= s1_r + idat_off_r;
    end
  end

  // classify the hit
  always_comb begin
    fin_status = ST_OK;
    fin_off    = '0;
    fin_len    = '0;
    if (nf_r) begin
      fin_status = ST_NOT_FOUND;
    end else if (!hit_r.has_ext) begin
      fin_status = ST_EXTENT_CNT;
    end else if (hit_r.method == METHOD_FILE) begin
      fin_off = s1_r;
      fin_len = hit_r.ext_len[31:0];
    end else if (hit_r.method == METHOD_IDAT) begin
      if (c1_r || c2_r || (s2_r > {32'd0, idat_sz_r})) begin
        fin_status = ST_IDAT_OVFL;
      end else begin
        fin_off = offs_r;
        fin_len = hit_r.ext_len[31:0];
      end
    end else begin
      fin_status = ST_UNSUPPORTED;
    end
  end

  // output valid: a new result wins over the drain of the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((byte_acc && in_box_last) || fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (byte_acc && in_box_last) begin
      out_kind_r   <= KIND_PARSE;
      out_status_r <= bad ? ST_PARSE_ERR : ST_OK;
      out_off_r    <= '0;
      out_len_r    <= '0;
    end else if (fin_go) begin
      out_kind_r   <= KIND_LOOKUP;
      out_status_r <= fin_status;
      out_off_r    <= fin_off;
      out_len_r    <= fin_len;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_status      = out_status_r;
  assign out_item_offset = out_off_r;
  assign out_item_length = out_len_r;

endmodule

// ===== design/ilbl_chk.sv =====
// Port-level checker for the item location parser, bound to the top level
`include "item_location_box_parse_and_lookup_macros.svh"

module ilbl_chk import ilbl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        in_box_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [2:0]  out_status,
  input logic [63:0] out_item_offset,
  input logic [31:0] out_item_length
);

  logic byte_mid, byte_end;

  assign byte_mid = in_valid && in_ready && (in_action == ACTION_BYTE) && !in_box_last;
  assign byte_end = in_valid && in_ready && (in_action == ACTION_BYTE) && in_box_last;

  // hold a waiting result
  `ILBL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // a byte inside a box raises no result
  `ILBL_ASSERT_NEXT(a_mid_quiet, byte_mid && !out_valid, !out_valid)
  // the last byte yields a parse status next cycle
  `ILBL_ASSERT_NEXT(a_end_status, byte_end,
    out_valid && (out_result_kind == KIND_PARSE) &&
    ((out_status == ST_OK) || (out_status == ST_PARSE_ERR)))
  // a failed answer carries no location
  `ILBL_ASSERT_NOW(a_fail_zero, out_valid && (out_status != ST_OK),
    (out_item_offset == 64'd0) && (out_item_length == 32'd0))

endmodule

bind item_location_box_parse_and_lookup ilbl_chk u_ilbl_chk (.*);

// ===== tb/item_location_box_parse_and_lookup_checker.sv =====
// Checker: tracks the item location parser, predicts each result and compares it
`timescale 1ns / 100ps

module item_location_box_parse_and_lookup_checker import ilbl_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_box_byte,
  input  logic        in_box_last,
  input  logic [31:0] in_item_id,
  input  logic [63:0] in_idat_offset,
  input  logic [31:0] in_idat_size,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_result_kind,
  input  logic [2:0]  out_status,
  input  logic [63:0] out_item_offset,
  input  logic [31:0] out_item_length,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic        kind;
    logic [2:0]  status;
    logic [63:0] offset;
    logic [31:0] length;
  } loc_result_t;

  loc_result_t  expected_q[$];
  loc_result_t  want;

  // Shadow copy of the parser state
  logic [7:0]   version;
  parse_phase_t phase;
  int           byte_cnt;
  logic [63:0]  acc;
  logic [3:0]   off_size, len_size, base_size, idx_size;
  int unsigned  item_total;
  int unsigned  items_done;
  logic         box_bad;
  entry_t       entries [TABLE_DEPTH];

  function automatic logic has_method();
    return (version == 8'd1) || (version == 8'd2);
  endfunction

  function automatic int field_len(parse_phase_t ph);
    case (ph)
      PH_COUNT, PH_ITEM: return (version < 8'd2) ? 2 : 4;
      PH_METHOD:         return has_method() ? 2 : 0;
      PH_DREF, PH_EXTCNT: return 2;
      PH_BASE:           return base_size;
      PH_INDEX:          return idx_size;
      PH_OFFSET:         return off_size;
      PH_LENGTH:         return len_size;
      default:           return 1;
    endcase
  endfunction

  function automatic parse_phase_t abort_box();
    box_bad = 1'b1;
    return PH_DONE;
  endfunction

  function automatic parse_phase_t next_entry();
    items_done++;
    return (items_done >= item_total) ? PH_DONE : PH_ITEM;
  endfunction

  // Store a completed field and pick the next phase
  function automatic parse_phase_t close_field(parse_phase_t ph, logic [63:0] v);
    int slot;
    slot = items_done % TABLE_DEPTH;
    case (ph)
      PH_SIZE_A: begin
        off_size = v[7:4];
        len_size = v[3:0];
        return PH_SIZE_B;
      end
      PH_SIZE_B: begin
        base_size = v[7:4];
        idx_size  = has_method() ? v[3:0] : 4'd0;
        if (!(off_size inside {4'd0, 4'd4, 4'd8}) || !(len_size inside {4'd0, 4'd4, 4'd8}) ||
            !(base_size inside {4'd0, 4'd4, 4'd8}) || !(idx_size inside {4'd0, 4'd4, 4'd8}))
          return abort_box();
        return PH_COUNT;
      end
      PH_COUNT: begin
        item_total = v[31:0];
        if (v > TABLE_DEPTH) return abort_box();
        return (v == 0) ? PH_DONE : PH_ITEM;
      end
      PH_ITEM: begin
        if (items_done >= TABLE_DEPTH) return abort_box();
        entries[slot].item_id = v[31:0];
        entries[slot].method  = METHOD_FILE;
        entries[slot].base    = '0;
        entries[slot].has_ext = 1'b0;
        entries[slot].ext_off = '0;
        entries[slot].ext_len = '0;
        return PH_METHOD;
      end
      PH_METHOD: begin
        entries[slot].method = v[3:0];
        return PH_DREF;
      end
      PH_DREF:   return (v != 0) ? abort_box() : PH_BASE;
      PH_BASE: begin
        entries[slot].base = v;
        return PH_EXTCNT;
      end
      PH_EXTCNT: begin
        if (v > 1) return abort_box();
        if (v == 1) begin
          entries[slot].has_ext = 1'b1;
          return PH_INDEX;
        end
        return next_entry();
      end
      PH_INDEX:  return PH_OFFSET;
      PH_OFFSET: begin
        entries[slot].ext_off = v;
        return PH_LENGTH;
      end
      PH_LENGTH: begin
        entries[slot].ext_len = v;
        return next_entry();
      end
      default:   return PH_DONE;
    endcase
  endfunction

  // Advance the parse by one payload byte; report status on the last one
  task automatic run_byte(input logic [7:0] b, input logic last);
    parse_phase_t ph;
    logic bad;
    if (phase == PH_SIZE_A) begin
      item_total = 0;
      items_done = 0;
      box_bad    = 1'b0;
      if (version > VERSION_MAX) phase = abort_box();
    end
    if (phase != PH_DONE) begin
      acc = {acc[55:0], b};
      byte_cnt++;
      if (byte_cnt >= field_len(phase)) begin
        ph = close_field(phase, acc);
        while (ph != PH_DONE && field_len(ph) == 0) ph = close_field(ph, '0);
        phase    = ph;
        acc      = '0;
        byte_cnt = 0;
      end
    end
    if (last) begin
      bad = box_bad || (phase != PH_DONE);
      expected_q.push_back('{KIND_PARSE, bad ? ST_PARSE_ERR : ST_OK, 64'd0, 32'd0});
      if (bad) begin
        item_total = 0;
        items_done = 0;
      end
      box_bad  = 1'b0;
      phase    = PH_SIZE_A;
      byte_cnt = 0;
      acc      = '0;
    end
  endtask

  // Search completed entries, first match wins
  task automatic answer_lookup(input logic [31:0] id, input logic [63:0] idat_off,
                               input logic [31:0] idat_sz);
    loc_result_t r;
    int n, hit;
    logic [63:0] s1, s2;
    r   = '{KIND_LOOKUP, ST_NOT_FOUND, 64'd0, 32'd0};
    n   = (items_done < TABLE_DEPTH) ? items_done : TABLE_DEPTH;
    hit = -1;
    for (int i = 0; i < n; i++)
      if (hit < 0 && entries[i].item_id == id) hit = i;
    if (hit >= 0) begin
      s1 = entries[hit].base + entries[hit].ext_off;
      s2 = s1 + entries[hit].ext_len;
      if (!entries[hit].has_ext) r.status = ST_EXTENT_CNT;
      else if (entries[hit].method == METHOD_FILE) begin
        r.status = ST_OK;
        r.offset = s1;
        r.length = entries[hit].ext_len[31:0];
      end else if (entries[hit].method == METHOD_IDAT) begin
        if (s1 < entries[hit].base || s2 < s1 || s2 > {32'd0, idat_sz})
          r.status = ST_IDAT_OVFL;
        else begin
          r.status = ST_OK;
          r.offset = s1 + idat_off;
          r.length = entries[hit].ext_len[31:0];
        end
      end else r.status = ST_UNSUPPORTED;
    end
    expected_q.push_back(r);
  endtask

  // Watch configuration, input and result channels
  always @(posedge clk) begin
    if (!rst_n) begin
      version    = 8'd0;
      phase      = PH_SIZE_A;
      byte_cnt   = 0;
      acc        = '0;
      off_size   = '0;
      len_size   = '0;
      base_size  = '0;
      idx_size   = '0;
      item_total = 0;
      items_done = 0;
      box_bad    = 1'b0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) version = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_action == ACTION_LOOKUP) answer_lookup(in_item_id, in_idat_offset, in_idat_size);
        else run_byte(in_box_byte, in_box_last);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_result_kind !== want.kind) begin
            $error("result_kind: expected %0h, got %0h", want.kind, out_result_kind);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_item_offset !== want.offset) begin
            $error("item_offset: expected %0h, got %0h", want.offset, out_item_offset);
            fail_count++;
          end
          if (out_item_length !== want.length) begin
            $error("item_length: expected %0h, got %0h", want.length, out_item_length);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/item_location_box_parse_and_lookup_tb.sv =====
// Testbench top: stimulus for the item location parser and the final verdict
`timescale 1ns / 100ps

module item_location_box_parse_and_lookup_tb import ilbl_pkg::*;;

  localparam int ITEM_GOAL   = 1800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, in_action, in_box_last;
  logic [7:0]  in_box_byte;
  logic [31:0] in_item_id, in_idat_size;
  logic [63:0] in_idat_offset;
  logic        out_valid, out_ready, out_result_kind;
  logic [2:0]  out_status;
  logic [63:0] out_item_offset;
  logic [31:0] out_item_length;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  int          fail_count, pending;

  int          cycles, sent, boxes, lookups;
  logic        no_idle, hold_req, hold_done;
  logic [7:0]  cur_version;
  logic [7:0]  box_q[$];

  item_location_box_parse_and_lookup u_dut (.*);

  item_location_box_parse_and_lookup_checker u_chk (.*);

  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one transaction after a random gap; return at the negedge after acceptance
  task automatic send_item(input logic act, input logic [7:0] b, input logic last,
                           input logic [31:0] id, input logic [63:0] ioff,
                           input logic [31:0] isz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_action      = act;
    in_box_byte    = b;
    in_box_last    = last;
    in_item_id     = id;
    in_idat_offset = ioff;
    in_idat_size   = isz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // Unused fields carry noise
  task automatic send_byte(input logic [7:0] b, input logic last);
    send_item(ACTION_BYTE, b, last, $urandom, {$urandom, $urandom}, $urandom);
  endtask

  task automatic send_lookup(input logic [31:0] id, input logic [63:0] ioff,
                             input logic [31:0] isz);
    send_item(ACTION_LOOKUP, 8'($urandom), 1'($urandom), id, ioff, isz);
    lookups++;
  endtask

  task automatic send_rand_lookup();
    send_lookup(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7),
                {$urandom, $urandom},
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000));
  endtask

  // Drain all results, then let the block settle
  task automatic go_idle();
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    go_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    cur_version = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic void put_field(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) box_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [3:0] pick_size();
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return 4'($urandom_range(0, 15));
    return (r % 3 == 0) ? 4'd0 : (r % 3 == 1) ? 4'd4 : 4'd8;
  endfunction

  function automatic logic [63:0] pick_value();
    return ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 300));
  endfunction

  // Build a mostly well-formed box for the current version and send it, with a lookup now and then
  task automatic send_box();
    logic [3:0]  osz, lsz, bsz, isz;
    logic [31:0] cnt, ext;
    int          idw, r, n, cut;
    logic        meth;
    box_q.delete();
    meth = (cur_version == 8'd1) || (cur_version == 8'd2);
    idw  = (cur_version < 8'd2) ? 2 : 4;
    osz  = pick_size();
    lsz  = pick_size();
    bsz  = pick_size();
    isz  = pick_size();
    box_q.push_back({osz, lsz});
    box_q.push_back({bsz, meth ? isz : 4'($urandom)});
    r = $urandom_range(0, 99);
    if (r == 0) cnt = 64;
    else if (r < 4) cnt = ($urandom_range(0, 1) ? 65 : $urandom);
    else if (r < 10) cnt = 0;
    else cnt = $urandom_range(1, 5);
    put_field(cnt, idw);
    n = (cnt > 64) ? 2 : cnt;
    for (int e = 0; e < n; e++) begin
      put_field(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 7), idw);
      if (meth) put_field(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1), 2);
      put_field(($urandom_range(0, 30) == 0) ? $urandom_range(1, 65535) : 0, 2);
      put_field(pick_value(), bsz);
      r = $urandom_range(0, 19);
      ext = (r == 0) ? $urandom_range(2, 65535) : (r < 3) ? 0 : 1;
      put_field(ext, 2);
      if (ext == 1) begin
        put_field(pick_value(), isz);
        put_field(pick_value(), osz);
        put_field(pick_value(), lsz);
      end
    end
    // Truncate or pad now and then
    r = $urandom_range(0, 9);
    if (r == 0) begin
      cut = $urandom_range(1, box_q.size());
      while (box_q.size() > cut) void'(box_q.pop_back());
    end else if (r == 1) begin
      repeat ($urandom_range(1, 3)) box_q.push_back(8'($urandom));
    end
    foreach (box_q[i]) begin
      if ($urandom_range(0, 19) == 0) send_rand_lookup();
      send_byte(box_q[i], i == box_q.size() - 1);
    end
    boxes++;
  endtask

  initial begin
    int r;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACTION_BYTE;
    in_box_byte = '0;
    in_box_last = 1'b0;
    in_item_id = '0;
    in_idat_offset = '0;
    in_idat_size = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cycles = 0;
    sent = 0;
    boxes = 0;
    lookups = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    cur_version = 8'd0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty table, zero-size fields, bad version, extreme lookups
    send_lookup(32'd0, 64'd0, 32'd0);
    write_version(8'd1);
    box_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
              8'h00, 8'h01};
    foreach (box_q[i]) send_byte(box_q[i], i == box_q.size() - 1);
    send_lookup(32'h0000FFFF, '1, '1);
    send_lookup('1, '1, '1);
    write_version(8'd255);
    send_byte(8'hFF, 1'b1);
    send_lookup(32'h0000FFFF, 64'd0, 32'd0);

    // Random boxes with lookups, version changes and a long result stall
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 9);
        write_version((r < 3) ? 8'd0 : (r < 5) ? 8'd1 : (r < 7) ? 8'd2 :
                      (r == 7) ? 8'd3 : (r == 8) ? 8'd255 : 8'($urandom));
      end
      no_idle = ($urandom_range(0, 7) == 0);
      if (!hold_done && sent > 600) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_box();
      repeat ($urandom_range(0, 2)) send_rand_lookup();
    end

    go_idle();
    $display("covered %0d transactions: %0d boxes over versions 0..255 and %0d lookups",
             sent, boxes, lookups);
    $display("%0d results still expected, %0d mismatches", pending, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
